// ===== src/stb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the spike time binner.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int EDGE_W      = 40;

   localparam logic CSR_BIN_WIDTH = 1'b0;
   localparam logic CSR_NUM_BINS  = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  channel;
      logic [11:0] position;
      logic [31:0] value;
   } cmd_type;

   typedef struct packed {
      logic [5:0]  bin_index;
      logic [12:0] spike_count;
      logic [12:0] start_position;
      logic        last_bin;
   } rsp_type;

   typedef struct packed {
      logic init;
      logic idle;
   } status_type;

endpackage
`default_nettype wire

// ===== src/stb_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_req_if
// Command channel: clear, write and query transactions.
// ----------------------------------------------------------------------------
interface stb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [2:0]  channel;
   logic [11:0] position;
   logic [31:0] spike_time;
   logic [31:0] query_time;

   modport source(output valid, command, channel, position, spike_time, query_time,
                  input ready);
   modport sink(input valid, command, channel, position, spike_time, query_time,
                output ready);
endinterface
`default_nettype wire

// ===== src/stb_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_rsp_if
// Result channel: one transaction per bin of a query.
// ----------------------------------------------------------------------------
interface stb_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  bin_index;
   logic [12:0] spike_count;
   logic [12:0] start_position;
   logic        last_bin;

   modport source(output valid, bin_index, spike_count, start_position, last_bin,
                  input ready);
   modport sink(input valid, bin_index, spike_count, start_position, last_bin,
                output ready);
endinterface
`default_nettype wire

// ===== src/stb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module stb_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  stb_pkg::cmd_type push_data,
   output logic             full,
   output logic             not_empty,
   output stb_pkg::cmd_type pop_data,
   input  wire              pop
);

   stb_pkg::cmd_type                mem_ff [0:stb_pkg::QUEUE_DEPTH-1];
   logic [stb_pkg::QUEUE_AW-1:0]    wr_ff, wr_in;
   logic [stb_pkg::QUEUE_AW-1:0]    rd_ff, rd_in;
   logic [stb_pkg::QUEUE_AW:0]      cnt_ff, cnt_in;
   logic                            do_push, do_pop;

   assign full      = (cnt_ff == (stb_pkg::QUEUE_AW+1)'(stb_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== src/stb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_front
// Accepts command transactions, drops those with no effect, queues the rest.
// ----------------------------------------------------------------------------
module stb_front #(
   parameter int CHANNELS           = 8,
   parameter int SPIKES_PER_CHANNEL = 4096
) (
   stb_req_if.sink          req,
   input  wire              hold,
   input  wire              q_full,
   output logic             q_push,
   output stb_pkg::cmd_type q_data
);

   logic keep;

   always_comb begin
      keep = 1'b0;
      if (32'(req.channel) < CHANNELS) begin
         case (req.command)
            stb_pkg::CMD_CLEAR: keep = 1'b1;
            stb_pkg::CMD_QUERY: keep = 1'b1;
            stb_pkg::CMD_WRITE: keep = (32'(req.position) < SPIKES_PER_CHANNEL);
            default:            keep = 1'b0;
         endcase
      end
   end

   assign req.ready         = !q_full && !hold;
   assign q_push            = req.valid && req.ready && keep;
   assign q_data.cmd        = req.command;
   assign q_data.channel    = req.channel;
   assign q_data.position   = req.position;
   assign q_data.value      = (req.command == stb_pkg::CMD_QUERY) ? req.query_time
                                                                   : req.spike_time;

endmodule
`default_nettype wire

// ===== src/stb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stb_back
// Executes queued commands: spike store loads, channel clears, bin walks.
// ----------------------------------------------------------------------------
module stb_back #(
   parameter int CHANNELS           = 8,
   parameter int SPIKES_PER_CHANNEL = 4096,
   parameter int MAX_BINS           = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cmd_valid,
   input  stb_pkg::cmd_type    cmd,
   output logic                cmd_pop,
   input  wire  [31:0]         bin_width,
   input  wire  [6:0]          num_bins,
   stb_rsp_if.source           rsp,
   output stb_pkg::status_type status
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W = $clog2(SPIKES_PER_CHANNEL);
   localparam int CNT_W = $clog2(SPIKES_PER_CHANNEL + 1);
   localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int D_W   = $clog2(MAX_BINS + 1);
   localparam int ST_AW = CH_W + POS_W;
   localparam int BS_AW = CH_W + BIN_W;
   localparam int EW    = stb_pkg::EDGE_W;

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CLEAR  = 3'd2;
   localparam logic [2:0] ST_QSTART = 3'd3;
   localparam logic [2:0] ST_QLOAD  = 3'd4;
   localparam logic [2:0] ST_WALK   = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   localparam logic [1:0] PH_BELOW = 2'd0;
   localparam logic [1:0] PH_EQ    = 2'd1;
   localparam logic [1:0] PH_CNT   = 2'd2;

   logic [31:0]      store_mem [0:(1<<ST_AW)-1];
   logic [CNT_W-1:0] bs_mem    [0:(1<<BS_AW)-1];

   logic [31:0]      store_rd_ff;
   logic [CNT_W-1:0] bs_rd_ff;

   logic             store_we;
   logic [ST_AW-1:0] store_waddr, store_raddr;
   logic             bs_we;
   logic [BS_AW-1:0] bs_waddr, bs_raddr;
   logic [CNT_W-1:0] bs_wdata;

   logic [2:0]       state_ff, state_in;
   logic [BS_AW-1:0] init_ff, init_in;
   logic [CNT_W-1:0] totals_ff [0:CHANNELS-1];
   logic [CNT_W-1:0] totals_in [0:CHANNELS-1];
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [D_W-1:0]   nb_ff, nb_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic signed [EW-1:0] upper_ff, upper_in, lower_ff, lower_in;
   logic [CNT_W-1:0] pos_ff, pos_in, start_ff, start_in, count_ff, count_in;
   logic [1:0]       phase_ff, phase_in;
   logic             out_valid_ff, out_valid_in;
   stb_pkg::rsp_type out_ff, out_in;

   logic [CH_W-1:0]  cmd_ch;
   logic [CNT_W-1:0] wr_total, clamp_start, start_final;
   logic signed [EW-1:0] w_s, q_s, v_s;
   logic             below, equal, in_bin, adv, done, last;

   assign cmd_ch   = CH_W'(cmd.channel);
   assign wr_total = CNT_W'(cmd.position) + CNT_W'(1);
   assign w_s      = $signed({{(EW-32){1'b0}}, bin_width});
   assign q_s      = $signed({{(EW-32){1'b0}}, cmd.value});
   assign v_s      = $signed({{(EW-32){1'b0}}, store_rd_ff});
   assign below    = v_s < lower_ff;
   assign equal    = v_s == lower_ff;
   assign in_bin   = (v_s > lower_ff) && (v_s < upper_ff);
   assign clamp_start = (bs_rd_ff > total_ff) ? total_ff : bs_rd_ff;
   assign start_final = (phase_ff == PH_BELOW) ? pos_ff : start_ff;
   assign last     = (({1'b0, d_ff} + 1'b1) == {1'b0, nb_ff});
   assign bs_raddr = {ch_ff, d_ff[BIN_W-1:0]};

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      totals_in    = totals_ff;
      ch_in        = ch_ff;
      total_in     = total_ff;
      nb_in        = nb_ff;
      d_in         = d_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      cmd_pop      = 1'b0;
      store_we     = 1'b0;
      store_waddr  = {cmd_ch, POS_W'(cmd.position)};
      store_raddr  = {ch_ff, POS_W'(pos_ff)};
      bs_we        = 1'b0;
      bs_waddr     = {ch_ff, d_ff[BIN_W-1:0]};
      bs_wdata     = '0;
      adv          = 1'b0;
      done         = 1'b0;

      case (state_ff)
         ST_INIT: begin
            bs_we    = 1'b1;
            bs_waddr = init_ff;
            init_in  = init_ff + 1'b1;
            if (init_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd_pop = 1'b1;
            if (cmd_valid) begin
               case (cmd.cmd)
                  stb_pkg::CMD_CLEAR: begin
                     totals_in[cmd_ch] = '0;
                     ch_in    = cmd_ch;
                     d_in     = '0;
                     state_in = ST_CLEAR;
                  end
                  stb_pkg::CMD_WRITE: begin
                     store_we = 1'b1;
                     if (wr_total > totals_ff[cmd_ch]) begin
                        totals_in[cmd_ch] = wr_total;
                     end
                  end
                  stb_pkg::CMD_QUERY: begin
                     ch_in    = cmd_ch;
                     total_in = totals_ff[cmd_ch];
                     if (num_bins == '0) begin
                        nb_in = D_W'(1);
                     end else if (32'(num_bins) > MAX_BINS) begin
                        nb_in = D_W'(MAX_BINS);
                     end else begin
                        nb_in = D_W'(num_bins);
                     end
                     d_in     = '0;
                     upper_in = q_s;
                     lower_in = q_s - w_s;
                     state_in = ST_QSTART;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            bs_we = 1'b1;
            d_in  = d_ff + 1'b1;
            if (d_ff == D_W'(MAX_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_QSTART: begin
            state_in = ST_QLOAD;
         end
         ST_QLOAD: begin
            pos_in      = clamp_start;
            start_in    = clamp_start;
            count_in    = '0;
            phase_in    = PH_BELOW;
            store_raddr = {ch_ff, POS_W'(clamp_start)};
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            store_raddr = {ch_ff, POS_W'(pos_ff + CNT_W'(1))};
            if (pos_ff >= total_ff) begin
               done = 1'b1;
            end else begin
               case (phase_ff)
                  PH_BELOW: begin
                     if (below) begin
                        adv = 1'b1;
                     end else begin
                        start_in = pos_ff;
                        if (equal) begin
                           adv      = 1'b1;
                           phase_in = PH_EQ;
                        end else if (in_bin) begin
                           adv      = 1'b1;
                           count_in = count_ff + 1'b1;
                           phase_in = PH_CNT;
                        end else begin
                           done = 1'b1;
                        end
                     end
                  end
                  PH_EQ: begin
                     if (equal) begin
                        adv = 1'b1;
                     end else if (in_bin) begin
                        adv      = 1'b1;
                        count_in = count_ff + 1'b1;
                        phase_in = PH_CNT;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: begin
                     if (in_bin) begin
                        adv      = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        done = 1'b1;
                     end
                  end
               endcase
            end
            if (adv) begin
               pos_in = pos_ff + 1'b1;
            end
            if (done) begin
               bs_we    = 1'b1;
               bs_wdata = start_final;
               start_in = start_final;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in          = 1'b1;
               out_in.bin_index      = 6'(d_ff);
               out_in.spike_count    = 13'(count_ff);
               out_in.start_position = 13'(start_ff);
               out_in.last_bin       = last;
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in     = d_ff + 1'b1;
                  upper_in = lower_ff;
                  lower_in = lower_ff - w_s;
                  state_in = ST_QSTART;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            totals_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         out_valid_ff <= out_valid_in;
         totals_ff    <= totals_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff    <= ch_in;
      total_ff <= total_in;
      nb_ff    <= nb_in;
      d_ff     <= d_in;
      upper_ff <= upper_in;
      lower_ff <= lower_in;
      pos_ff   <= pos_in;
      start_ff <= start_in;
      count_ff <= count_in;
      phase_ff <= phase_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= cmd.value;
      end
      store_rd_ff <= store_mem[store_raddr];
   end

   always_ff @(posedge clock) begin
      if (bs_we) begin
         bs_mem[bs_waddr] <= bs_wdata;
      end
      bs_rd_ff <= bs_mem[bs_raddr];
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.bin_index      = out_ff.bin_index;
   assign rsp.spike_count    = out_ff.spike_count;
   assign rsp.start_position = out_ff.start_position;
   assign rsp.last_bin       = out_ff.last_bin;
   assign status.init        = (state_ff == ST_INIT);
   assign status.idle        = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

// ===== src/spike_time_binner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spike_time_binner
// Per-channel spike store with binned spike counts per query.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  req     | in  | clear / write spike time / query bins
//  rsp     | out | one per bin: index, count, start position, last flag
//  csr     | in  | write of bin_width (0) or num_bins (1)
//
//  A write needs no further back-end state; a clear sweeps the channel's MAX_BINS
//  entries of the bin start memory. A query passes, per bin, through the
//  start, load, walk and emit states, the walk stepping over stored spikes.
//  After reset a clearing pass over all CHANNELS*MAX_BINS bin start entries,
//  rounded up to powers of two (512 by default), holds req.ready low.
//  A four-entry queue separates intake from execution; rsp stalls hold the
//  walk in its emit step.
// ----------------------------------------------------------------------------
module spike_time_binner #(
   parameter int CHANNELS           = 8,
   parameter int SPIKES_PER_CHANNEL = 4096,
   parameter int MAX_BINS           = 64
) (
   input  wire         clock,
   input  wire         reset,
   stb_req_if.sink     req,
   stb_rsp_if.source   rsp,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [31:0] csr_wdata
);

   logic [31:0]         bin_width_ff;
   logic [6:0]          num_bins_ff;
   logic                q_push, q_full, q_valid, q_pop;
   stb_pkg::cmd_type    q_wdata, q_rdata;
   stb_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= 32'd20;
         num_bins_ff  <= 7'd50;
      end else if (csr_we) begin
         if (csr_index == stb_pkg::CSR_BIN_WIDTH) begin
            bin_width_ff <= csr_wdata;
         end else begin
            num_bins_ff <= csr_wdata[6:0];
         end
      end
   end

   stb_front #(
      .CHANNELS           (CHANNELS),
      .SPIKES_PER_CHANNEL (SPIKES_PER_CHANNEL)
   ) u_front (
      .req    (req),
      .hold   (status.init),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   stb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .not_empty (q_valid),
      .pop_data  (q_rdata),
      .pop       (q_pop)
   );

   stb_back #(
      .CHANNELS           (CHANNELS),
      .SPIKES_PER_CHANNEL (SPIKES_PER_CHANNEL),
      .MAX_BINS           (MAX_BINS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_rdata),
      .cmd_pop   (q_pop),
      .bin_width (bin_width_ff),
      .num_bins  (num_bins_ff),
      .rsp       (rsp),
      .status    (status)
   );

   a_no_req_in_init: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> !status.init)
      else $error("transaction accepted during clearing pass");

   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !status.init)
      else $error("result during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable({rsp.bin_index,
         rsp.spike_count, rsp.start_position, rsp.last_bin})))
      else $error("stalled result transaction changed");

endmodule
`default_nettype wire

// ===== bench/tb_spike_time_binner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spike_time_binner
// Self-checking bench for the spike time binner: directed loads and queries,
// then randomized spike trains and queries under random stalls on both sides.
// Bin results are predicted in the bench and compared per field.
// ----------------------------------------------------------------------------
module tb_spike_time_binner;

   localparam int NCH = 8;
   localparam int NSP = 4096;
   localparam int NBMAX = 64;

   logic clock;
   logic reset;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   stb_req_if req ();
   stb_rsp_if rsp ();

   spike_time_binner i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [31:0] spike_mem [NCH][NSP];
   int unsigned spike_total [NCH];
   int unsigned kept_start [NCH][NBMAX];
   logic [31:0] width_reg;
   logic [6:0]  bins_reg;

   stb_pkg::rsp_type bin_queue [$];
   int mismatches;
   bit hold_rsp;
   int hold_cycles;
   // per-channel fill for random trains
   logic [31:0] last_time [NCH];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void predict_bins(int ch, logic [31:0] qt);
      int unsigned nb, st, p, cnt, tot;
      longint upper, lower;
      stb_pkg::rsp_type r;
      nb = (bins_reg == 0) ? 1 : (bins_reg > NBMAX ? NBMAX : bins_reg);
      tot = spike_total[ch];
      for (int d = 0; d < nb; d++) begin
         upper = longint'(qt) - longint'(d) * longint'(width_reg);
         lower = upper - longint'(width_reg);
         st = kept_start[ch][d];
         if (st > tot) st = tot;
         while (st < tot && longint'(spike_mem[ch][st]) < lower) st++;
         kept_start[ch][d] = st;
         p = st;
         cnt = 0;
         while (p < tot && longint'(spike_mem[ch][p]) == lower) p++;
         while (p < tot && longint'(spike_mem[ch][p]) > lower
                && longint'(spike_mem[ch][p]) < upper) begin
            cnt++;
            p++;
         end
         r.bin_index = d[5:0];
         r.spike_count = cnt[12:0];
         r.start_position = st[12:0];
         r.last_bin = (d + 1 == nb);
         bin_queue.push_back(r);
      end
   endfunction

   function automatic void apply_command(logic [1:0] c, logic [2:0] ch, logic [11:0] pos,
                                         logic [31:0] st, logic [31:0] qt);
      if (c == stb_pkg::CMD_CLEAR) begin
         spike_total[ch] = 0;
         for (int d = 0; d < NBMAX; d++) kept_start[ch][d] = 0;
      end else if (c == stb_pkg::CMD_WRITE) begin
         spike_mem[ch][pos] = st;
         if (pos + 1 > spike_total[ch]) spike_total[ch] = pos + 1;
      end else if (c == stb_pkg::CMD_QUERY) begin
         predict_bins(ch, qt);
      end
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         req.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_cmd(logic [1:0] c, logic [2:0] ch, logic [11:0] pos,
                           logic [31:0] st, logic [31:0] qt, bit gaps = 1);
      if (gaps) idle_gap();
      req.valid <= 1'b1;
      req.command <= c;
      req.channel <= ch;
      req.position <= pos;
      req.spike_time <= st;
      req.query_time <= qt;
      do @(posedge clock); while (!req.ready);
      apply_command(c, ch, pos, st, qt);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req.valid <= 1'b0;
      while (bin_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (600) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == stb_pkg::CSR_BIN_WIDTH) width_reg = val;
      else bins_reg = val[6:0];
      @(posedge clock);
   endtask

   // clear a channel, then load count non-decreasing spike times from position 0
   task automatic load_train(logic [2:0] ch, int count, logic [31:0] t0, int maxstep);
      logic [31:0] t;
      t = t0;
      send_cmd(stb_pkg::CMD_CLEAR, ch, 12'($urandom), $urandom, $urandom);
      for (int i = 0; i < count; i++) begin
         send_cmd(stb_pkg::CMD_WRITE, ch, i[11:0], t, $urandom);
         t = t + $urandom_range(0, maxstep);
      end
      last_time[ch] = t;
   endtask

   task automatic test_directed();
      write_csr(stb_pkg::CSR_BIN_WIDTH, 32'd10);
      write_csr(stb_pkg::CSR_NUM_BINS, 32'd4);
      send_cmd(stb_pkg::CMD_QUERY, 3'd0, 12'd0, 32'd0, 32'd100);
      send_cmd(stb_pkg::CMD_CLEAR, 3'd1, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_cmd(stb_pkg::CMD_WRITE, 3'd1, 12'd0, 32'd0, 32'd0);
      send_cmd(stb_pkg::CMD_WRITE, 3'd1, 12'd1, 32'd70, 32'd0);
      send_cmd(stb_pkg::CMD_WRITE, 3'd1, 12'd2, 32'd80, 32'd0);
      send_cmd(stb_pkg::CMD_WRITE, 3'd1, 12'd3, 32'd85, 32'd0);
      send_cmd(stb_pkg::CMD_WRITE, 3'd1, 12'd4, 32'd90, 32'd0);
      send_cmd(stb_pkg::CMD_QUERY, 3'd1, 12'd0, 32'd0, 32'd100);
      send_cmd(stb_pkg::CMD_QUERY, 3'd1, 12'd0, 32'd0, 32'd100);
      send_cmd(stb_pkg::CMD_UNUSED, 3'd1, 12'd0, 32'd0, 32'd100);
      send_cmd(stb_pkg::CMD_CLEAR, 3'd7, 12'd0, 32'd0, 32'd0);
      for (int i = 0; i < 4; i++)
         send_cmd(stb_pkg::CMD_WRITE, 3'd7, 12'(i), 32'hFFFF_FFF0 + 32'(4 * i), 32'd0);
      send_cmd(stb_pkg::CMD_WRITE, 3'd7, 12'd4, 32'hFFFF_FFFF, 32'd0);
      send_cmd(stb_pkg::CMD_QUERY, 3'd7, 12'd0, 32'd0, 32'hFFFF_FFFF);
      // stale start: shrink channel 1 by clearing and reloading fewer spikes
      send_cmd(stb_pkg::CMD_CLEAR, 3'd1, 12'd0, 32'd0, 32'd0);
      send_cmd(stb_pkg::CMD_WRITE, 3'd1, 12'd0, 32'd5, 32'd0);
      send_cmd(stb_pkg::CMD_QUERY, 3'd1, 12'd0, 32'd0, 32'd0);
      drain();
      write_csr(stb_pkg::CSR_BIN_WIDTH, 32'd0);
      write_csr(stb_pkg::CSR_NUM_BINS, 32'd0);
      send_cmd(stb_pkg::CMD_QUERY, 3'd1, 12'd0, 32'd0, 32'd5);
      drain();
      write_csr(stb_pkg::CSR_BIN_WIDTH, 32'hFFFF_FFFF);
      write_csr(stb_pkg::CSR_NUM_BINS, 32'd127);
      send_cmd(stb_pkg::CMD_QUERY, 3'd7, 12'd0, 32'd0, 32'hFFFF_FFFF);
      drain();
      write_csr(stb_pkg::CSR_NUM_BINS, 32'd64);
      write_csr(stb_pkg::CSR_BIN_WIDTH, 32'd1);
      send_cmd(stb_pkg::CMD_QUERY, 3'd7, 12'd0, 32'd0, 32'hFFFF_FFF8);
      drain();
   endtask

   task automatic test_backpressure();
      write_csr(stb_pkg::CSR_BIN_WIDTH, 32'd16);
      write_csr(stb_pkg::CSR_NUM_BINS, 32'd8);
      load_train(3'd2, 12, 32'd100, 12);
      hold_cycles = 400;
      hold_rsp = 1'b1;
      for (int i = 0; i < 8; i++)
         send_cmd(stb_pkg::CMD_QUERY, 3'd2, 12'd0, 32'd0, 32'd100 + 32'(20 * i), 0);
      drain();
   endtask

   task automatic test_random();
      int settings [4][2] = '{'{5, 3}, '{1, 64}, '{37, 12}, '{1000, 2}};
      logic [2:0] ch;
      logic [31:0] qt;
      for (int s = 0; s < 4; s++) begin
         write_csr(stb_pkg::CSR_BIN_WIDTH, 32'(settings[s][0]));
         write_csr(stb_pkg::CSR_NUM_BINS, 32'(settings[s][1]));
         for (int c = 0; c < NCH; c++)
            load_train(c[2:0], $urandom_range(1, 3),
                       $urandom_range(0, 200) + (c == 5 ? 32'hFFFF_FF00 : 0), 40);
         for (int i = 0; i < 12; i++) begin
            ch = 3'($urandom_range(0, NCH - 1));
            case ($urandom_range(0, 9))
               0: send_cmd(stb_pkg::CMD_UNUSED, ch, 12'($urandom), $urandom, $urandom);
               1, 2: if (spike_total[ch] < NSP && last_time[ch] < 32'hFFFF_FF00) begin
                  last_time[ch] = last_time[ch] + $urandom_range(0, 30);
                  send_cmd(stb_pkg::CMD_WRITE, ch, spike_total[ch][11:0], last_time[ch],
                           $urandom);
               end
               default: begin
                  qt = last_time[ch] + $urandom_range(0, 60) - 30;
                  if ($urandom_range(0, 7) == 0) qt = $urandom;
                  send_cmd(stb_pkg::CMD_QUERY, ch, 12'($urandom), $urandom, qt);
               end
            endcase
         end
         drain();
      end
   endtask

   // receiver
   always @(posedge clock) begin
      bit rdy;
      rdy = ($urandom_range(0, 3) != 0) && ($urandom_range(0, 40) != 0);
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp.ready <= 1'b0;
         if (hold_cycles == 0) hold_rsp <= 1'b0;
         else hold_cycles <= hold_cycles - 1;
      end else begin
         rsp.ready <= rdy;
      end
   end

   always @(posedge clock) begin
      stb_pkg::rsp_type exp;
      if (!reset && rsp.valid && rsp.ready) begin
         if (bin_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected bin transaction %0d", rsp.bin_index);
         end else begin
            exp = bin_queue.pop_front();
            if (exp.bin_index !== rsp.bin_index || exp.spike_count !== rsp.spike_count
                || exp.start_position !== rsp.start_position
                || exp.last_bin !== rsp.last_bin) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("bin exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           exp.bin_index, exp.spike_count, exp.start_position, exp.last_bin,
                           rsp.bin_index, rsp.spike_count, rsp.start_position,
                           rsp.last_bin);
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("spike_time_binner: mismatch");
      $finish;
   end

   initial begin
      mismatches = 0;
      hold_rsp = 1'b0;
      hold_cycles = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.command = '0;
      req.channel = '0;
      req.position = '0;
      req.spike_time = '0;
      req.query_time = '0;
      width_reg = 32'd20;
      bins_reg = 7'd50;
      for (int c = 0; c < NCH; c++) begin
         spike_total[c] = 0;
         last_time[c] = 0;
         for (int d = 0; d < NBMAX; d++) kept_start[c][d] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      drain();
      if (mismatches == 0 && bin_queue.size() == 0)
         $display("spike_time_binner: match");
      else
         $display("spike_time_binner: mismatch");
      $finish;
   end
endmodule
